// ===== design/mesh_iwc_pkg.sv =====
// mesh_iwc_pkg: shared constants and types for the mesh index weld and compaction block
// used by mesh_index_weld_compact; no other dependencies
package mesh_iwc_pkg;

	localparam int DATA_W       = 32;
	localparam int CFG_W        = 11;
	localparam int OP_W         = 3;
	localparam int ADDR_W       = 12;
	localparam int S_TDATA_W    = 48;
	localparam int M_TDATA_W    = 40;
	localparam int CFG_IDX_W    = 1;

	localparam int MAX_VERTS_DEF = 1024;
	localparam int MAX_FACES_DEF = 1024;

	localparam logic [DATA_W-1:0] NO_VERTEX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FACE_COUNT   = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_REP   = 3'd0,
		OP_LOAD_IDX   = 3'd1,
		OP_WELD       = 3'd2,
		OP_READ_IDX   = 3'd3,
		OP_READ_REMAP = 3'd4
	} op_t;

endpackage

// ===== design/mesh_index_weld_compact.sv =====
// mesh_index_weld_compact: welds a triangle index list onto vertex representatives and
// compacts used vertices into a dense numbering, with a remap table (new to old)
// depends on mesh_iwc_pkg
// a load answers in the cycle after the transfer; a read goes through ST_RDI or ST_RDR
// weld: clear marks, mark reps and weld indices, rank used vertices, fill remap with
// NO_VERTEX, rewrite indices to ranks, report the compact count; each index pass has a
// read and, if in range, a write state, as each table has one registered read port;
// one command at a time: a load every cycle while results are taken, a read waits for
// its result; reset clears control state and config registers, tables stay undefined until written
module mesh_index_weld_compact #(
	parameter int MAX_VERTS = mesh_iwc_pkg::MAX_VERTS_DEF,
	parameter int MAX_FACES = mesh_iwc_pkg::MAX_FACES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mesh_iwc_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [mesh_iwc_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mesh_iwc_pkg::S_TDATA_W-1:0]   s_tdata,   // op[2:0], addr[14:3], value[46:15], pad
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mesh_iwc_pkg::M_TDATA_W-1:0]   m_tdata    // data[31:0], error[32], pad
);

	localparam int DW     = mesh_iwc_pkg::DATA_W;
	localparam int IDEPTH = 3 * MAX_FACES;
	localparam int VAW    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
	localparam int IAW    = $clog2(IDEPTH);
	localparam int NVW    = $clog2(MAX_VERTS + 1);
	localparam int NFW    = $clog2(MAX_FACES + 1);
	localparam int NIW    = $clog2(IDEPTH + 1);
	localparam int CW     = (NVW > NIW) ? NVW : NIW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDI, ST_RDR, ST_CLR, ST_REP_A, ST_REP_B, ST_REP_C,
		ST_RNK_A, ST_RNK_B, ST_FILL, ST_REW_A, ST_REW_B, ST_REW_C, ST_DONE
	} state_t;

	state_t state_q;

	logic [mesh_iwc_pkg::CFG_W-1:0] vc_q, fc_q;
	logic [CW-1:0]   ctr_q;
	logic [NVW-1:0]  nvc_q;
	logic            mv_q;
	logic [DW-1:0]   data_q;
	logic            err_q;

	// tables
	logic [DW-1:0]  rep_mem   [MAX_VERTS];
	logic [DW-1:0]  idx_mem   [IDEPTH];
	logic [DW-1:0]  remap_mem [MAX_VERTS];
	logic           used_mem  [MAX_VERTS];
	logic [NVW-1:0] rank_mem  [MAX_VERTS];

	logic [DW-1:0]  rep_rd_q, idx_rd_q, remap_rd_q;
	logic           used_rd_q;
	logic [NVW-1:0] rank_rd_q;

	logic           rep_we, idx_we, remap_we, used_we, rank_we;
	logic [VAW-1:0] rep_wa, remap_wa, used_wa, rank_wa;
	logic [IAW-1:0] idx_wa;
	logic [DW-1:0]  rep_wd, idx_wd, remap_wd;
	logic           used_wd;
	logic [NVW-1:0] rank_wd;
	logic [VAW-1:0] rep_ra, remap_ra, used_ra, rank_ra;
	logic [IAW-1:0] idx_ra;

	logic                    s_acc;
	mesh_iwc_pkg::op_t       op_in;
	logic [mesh_iwc_pkg::ADDR_W-1:0] addr_in;
	logic [DW-1:0]           value_in;
	logic [NVW-1:0]          nv;
	logic [NFW-1:0]          fce;
	logic [NIW-1:0]          ni;
	logic                    ok_v, ok_i;
	logic                    ctr_lt_nv, ctr_lt_ni;
	logic                    idx_rd_ok, rep_rd_ok;

	assign op_in    = mesh_iwc_pkg::op_t'(s_tdata[2:0]);
	assign addr_in  = s_tdata[14:3];
	assign value_in = s_tdata[46:15];

	assign s_tready = (state_q == ST_IDLE) && (!mv_q || m_tready);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = mv_q;
	assign m_tdata  = {7'd0, err_q, data_q};

	// effective counts
	always_comb begin
		nv  = (32'(vc_q) > 32'(MAX_VERTS)) ? NVW'(MAX_VERTS) : NVW'(vc_q);
		fce = (32'(fc_q) > 32'(MAX_FACES)) ? NFW'(MAX_FACES) : NFW'(fc_q);
		ni  = NIW'(32'(fce) * 3);
	end

	assign ok_v      = 32'(addr_in) < 32'(nv);
	assign ok_i      = 32'(addr_in) < 32'(ni);
	assign ctr_lt_nv = 32'(ctr_q) < 32'(nv);
	assign ctr_lt_ni = 32'(ctr_q) < 32'(ni);
	assign idx_rd_ok = idx_rd_q < 32'(nv);
	assign rep_rd_ok = rep_rd_q < 32'(nv);

	// memory port control
	always_comb begin
		rep_we   = 1'b0;
		rep_wa   = VAW'(addr_in);
		rep_wd   = value_in;
		idx_we   = 1'b0;
		idx_wa   = IAW'(ctr_q);
		idx_wd   = value_in;
		remap_we = 1'b0;
		remap_wa = VAW'(ctr_q);
		remap_wd = mesh_iwc_pkg::NO_VERTEX;
		used_we  = 1'b0;
		used_wa  = VAW'(ctr_q);
		used_wd  = 1'b0;
		rank_we  = 1'b0;
		rank_wa  = VAW'(ctr_q);
		rank_wd  = nvc_q;
		rep_ra   = VAW'(idx_rd_q);
		idx_ra   = IAW'(ctr_q);
		remap_ra = VAW'(addr_in);
		used_ra  = VAW'(ctr_q);
		rank_ra  = VAW'(idx_rd_q);
		unique case (state_q)
			ST_IDLE: begin
				idx_ra = IAW'(addr_in);
				if (s_acc && op_in == mesh_iwc_pkg::OP_LOAD_REP && ok_v) begin
					rep_we = 1'b1;
				end
				if (s_acc && op_in == mesh_iwc_pkg::OP_LOAD_IDX && ok_i) begin
					idx_we = 1'b1;
					idx_wa = IAW'(addr_in);
				end
			end
			ST_CLR: begin
				used_we = ctr_lt_nv;
			end
			ST_REP_C: begin
				idx_we  = 1'b1;
				idx_wd  = rep_rd_q;
				used_we = rep_rd_ok;
				used_wa = VAW'(rep_rd_q);
				used_wd = 1'b1;
			end
			ST_RNK_B: begin
				remap_we = used_rd_q;
				remap_wa = VAW'(nvc_q);
				remap_wd = 32'(ctr_q);
				rank_we  = used_rd_q;
			end
			ST_FILL: begin
				remap_we = ctr_lt_nv;
			end
			ST_REW_C: begin
				idx_we = 1'b1;
				idx_wd = 32'(rank_rd_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rep_we) begin
			rep_mem[rep_wa] <= rep_wd;
		end
		rep_rd_q <= rep_mem[rep_ra];
	end

	always_ff @(posedge clk) begin
		if (idx_we) begin
			idx_mem[idx_wa] <= idx_wd;
		end
		idx_rd_q <= idx_mem[idx_ra];
	end

	always_ff @(posedge clk) begin
		if (remap_we) begin
			remap_mem[remap_wa] <= remap_wd;
		end
		remap_rd_q <= remap_mem[remap_ra];
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_wa] <= used_wd;
		end
		used_rd_q <= used_mem[used_ra];
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_wa] <= rank_wd;
		end
		rank_rd_q <= rank_mem[rank_ra];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= '0;
			fc_q <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == mesh_iwc_pkg::REG_VERTEX_COUNT) begin
				vc_q <= cfg_wdata;
			end
			if (cfg_addr == mesh_iwc_pkg::REG_FACE_COUNT) begin
				fc_q <= cfg_wdata;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctr_q   <= '0;
			nvc_q   <= '0;
			mv_q    <= 1'b0;
			data_q  <= '0;
			err_q   <= 1'b0;
		end else begin
			if (m_tready) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (op_in)
							mesh_iwc_pkg::OP_LOAD_REP: begin
								mv_q   <= 1'b1;
								data_q <= '0;
								err_q  <= !ok_v;
							end
							mesh_iwc_pkg::OP_LOAD_IDX: begin
								mv_q   <= 1'b1;
								data_q <= '0;
								err_q  <= !ok_i;
							end
							mesh_iwc_pkg::OP_WELD: begin
								ctr_q   <= '0;
								nvc_q   <= '0;
								state_q <= ST_CLR;
							end
							mesh_iwc_pkg::OP_READ_IDX: begin
								if (ok_i) begin
									state_q <= ST_RDI;
								end else begin
									mv_q   <= 1'b1;
									data_q <= '0;
									err_q  <= 1'b1;
								end
							end
							mesh_iwc_pkg::OP_READ_REMAP: begin
								if (ok_v) begin
									state_q <= ST_RDR;
								end else begin
									mv_q   <= 1'b1;
									data_q <= '0;
									err_q  <= 1'b1;
								end
							end
							default: begin
								mv_q   <= 1'b1;
								data_q <= '0;
								err_q  <= 1'b0;
							end
						endcase
					end
				end
				ST_RDI: begin
					mv_q    <= 1'b1;
					data_q  <= idx_rd_q;
					err_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_RDR: begin
					mv_q    <= 1'b1;
					data_q  <= remap_rd_q;
					err_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_CLR: begin
					if (ctr_lt_nv) begin
						ctr_q <= ctr_q + 1'b1;
					end else begin
						ctr_q   <= '0;
						state_q <= ST_REP_A;
					end
				end
				ST_REP_A: begin
					if (ctr_lt_ni) begin
						state_q <= ST_REP_B;
					end else begin
						ctr_q   <= '0;
						state_q <= ST_RNK_A;
					end
				end
				ST_REP_B: begin
					if (idx_rd_ok) begin
						state_q <= ST_REP_C;
					end else begin
						ctr_q   <= ctr_q + 1'b1;
						state_q <= ST_REP_A;
					end
				end
				ST_REP_C: begin
					ctr_q   <= ctr_q + 1'b1;
					state_q <= ST_REP_A;
				end
				ST_RNK_A: begin
					if (ctr_lt_nv) begin
						state_q <= ST_RNK_B;
					end else begin
						ctr_q   <= CW'(nvc_q);
						state_q <= ST_FILL;
					end
				end
				ST_RNK_B: begin
					if (used_rd_q) begin
						nvc_q <= nvc_q + 1'b1;
					end
					ctr_q   <= ctr_q + 1'b1;
					state_q <= ST_RNK_A;
				end
				ST_FILL: begin
					if (ctr_lt_nv) begin
						ctr_q <= ctr_q + 1'b1;
					end else begin
						ctr_q   <= '0;
						state_q <= ST_REW_A;
					end
				end
				ST_REW_A: begin
					if (ctr_lt_ni) begin
						state_q <= ST_REW_B;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_REW_B: begin
					if (idx_rd_ok) begin
						state_q <= ST_REW_C;
					end else begin
						ctr_q   <= ctr_q + 1'b1;
						state_q <= ST_REW_A;
					end
				end
				ST_REW_C: begin
					ctr_q   <= ctr_q + 1'b1;
					state_q <= ST_REW_A;
				end
				ST_DONE: begin
					mv_q    <= 1'b1;
					data_q  <= {21'd0, 11'(nvc_q)};
					err_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	a_rank_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rank_we |-> (32'(nvc_q) < 32'(nv)))
		else $error("compact number reached vertex count");

	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_we && used_wd) |-> (32'(used_wa) < 32'(nv)))
		else $error("used mark outside vertex range");

	a_weld_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && op_in == mesh_iwc_pkg::OP_WELD) |=> (state_q == ST_CLR))
		else $error("weld transfer did not start the clear pass");

	a_fill_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> ((32'(ctr_q) >= 32'(nvc_q)) && (32'(ctr_q) <= 32'(nv))))
		else $error("remap fill counter out of bounds");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mv_q) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_RDI ||
			$past(state_q) == ST_RDR || $past(state_q) == ST_DONE))
		else $error("result raised mid weld");

endmodule
